// ----- hdl/alnd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package alnd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_IS_TREE      = 3'd0;
  localparam logic [2:0] REG_COARSE_ROOT  = 3'd1;
  localparam logic [2:0] REG_STEM_LEAF    = 3'd2;
  localparam logic [2:0] REG_LIVE_WOOD_FR = 3'd3;
  localparam logic [2:0] REG_LEAF_CN      = 3'd4;
  localparam logic [2:0] REG_FROOT_CN     = 3'd5;
  localparam logic [2:0] REG_LIVE_CN      = 3'd6;
  localparam logic [2:0] REG_DEAD_CN      = 3'd7;

  localparam logic [24:0] ONE_Q24  = 25'h100_0000;
  localparam logic [30:0] SAT31    = 31'h7FFF_FFFF;
  localparam logic [15:0] CN_MIN   = 16'd16;
  localparam logic [12:0] FRAC_ONE = 13'd4096;

  typedef logic [30:0] flux_t;

  // raise C:N ratios below 1.0 to 1.0
  function automatic logic [15:0] cn_floor(input logic [15:0] cn);
    cn_floor = (cn < CN_MIN) ? CN_MIN : cn;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/alnd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per register stage.
// Requires in_rem < in_den; dividend is {in_rem, in_lo}.
module alnd_div #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [QW-1:0] in_lo,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic [PW-1:0]      out_pay
);

  logic          vld [QW];
  logic [DW-1:0] rem [QW];
  logic [QW-1:0] wrd [QW];
  logic [DW-1:0] den [QW];
  logic [PW-1:0] pay [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [QW-1:0] w_in;
    logic [DW-1:0] d_in;
    logic [PW-1:0] p_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [QW:0]   w_ext;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = in_rem;
      assign w_in = in_lo;
      assign d_in = in_den;
      assign p_in = in_pay;
    end else begin : g_rest
      assign v_in = vld[i-1];
      assign r_in = rem[i-1];
      assign w_in = wrd[i-1];
      assign d_in = den[i-1];
      assign p_in = pay[i-1];
    end

    always_comb begin
      trial = {r_in, w_in[QW-1]};
      diff  = trial - {1'b0, d_in};
      take  = (trial >= {1'b0, d_in});
      w_ext = {w_in, take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? diff[DW-1:0] : trial[DW-1:0];
        wrd[i] <= w_ext[QW-1:0];
        den[i] <= d_in;
        pay[i] <= p_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = wrd[QW-1];
  assign out_pay   = pay[QW-1];

endmodule
`default_nettype wire

// ----- hdl/allometric_nitrogen_demand.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Potential plant nitrogen demand of one day. Each input word carries gross and potential
// photosynthesis to the carbon pool, maintenance respiration and the pool balance (all signed
// Q16.16); each output word returns available carbon and nitrogen demand (Q16.16, saturated).
// The block is a fully pipelined datapath with no state between words: a new word is taken
// every cycle while the skid register is empty. It is a chain of four bit-per-stage
// dividers (root fraction 24, leaf fraction 25, the four N:C terms in parallel 33, demand 31)
// plus eight arithmetic stages. An output register and a skid register let the pipeline take
// one more word while a result waits on m_tready. Configuration registers are written through
// cfg_we/cfg_index/cfg_data, by the user only while idle; the block does not enforce this.
module allometric_nitrogen_demand
  import alnd_pkg::*;
#(
  parameter int GROWTH_RESP_Q12 = 1229
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [31:0] gross_to_pool, [63:32] potential_to_pool, [95:64] maint_resp,
  // [127:96] pool_balance
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [30:0] avail_carbon, [61:31] nitrogen_demand, [63:62] zero
  output logic [63:0]       m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam logic [13:0] RESP_SCALE = 14'(4096 + GROWTH_RESP_Q12);

  // configuration registers
  logic        is_tree;
  logic [15:0] coarse_root_per_stem;
  logic [15:0] stem_per_leaf;
  logic [12:0] live_wood_fraction;
  logic [15:0] leaf_cn;
  logic [15:0] fine_root_cn;
  logic [15:0] live_wood_cn;
  logic [15:0] dead_wood_cn;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_tree              <= 1'b1;
      coarse_root_per_stem <= 16'd901;
      stem_per_leaf        <= 16'd9011;
      live_wood_fraction   <= 13'd410;
      leaf_cn              <= 16'd672;
      fine_root_cn         <= 16'd672;
      live_wood_cn         <= 16'd800;
      dead_wood_cn         <= 16'd7968;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IS_TREE:      is_tree              <= cfg_data[0];
        REG_COARSE_ROOT:  coarse_root_per_stem <= cfg_data;
        REG_STEM_LEAF:    stem_per_leaf        <= cfg_data;
        REG_LIVE_WOOD_FR: live_wood_fraction   <= cfg_data[12:0];
        REG_LEAF_CN:      leaf_cn              <= cfg_data;
        REG_FROOT_CN:     fine_root_cn         <= cfg_data;
        REG_LIVE_CN:      live_wood_cn         <= cfg_data;
        REG_DEAD_CN:      dead_wood_cn         <= cfg_data;
        default:          ;
      endcase
    end
  end

  // the whole pipeline advances together; it halts only while the skid register is full
  logic en;
  logic sk_v;
  assign en       = !sk_v;
  assign s_tready = en;

  // ---- stage A: capture the input word
  logic        a_v;
  logic [31:0] a_g, a_p, a_mr, a_pool;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_g    <= s_tdata[31:0];
      a_p    <= s_tdata[63:32];
      a_mr   <= s_tdata[95:64];
      a_pool <= s_tdata[127:96];
    end
  end

  // ---- stage B: available carbon, root fraction operands, carbon allometry K
  logic signed [32:0] b_net1;
  logic [32:0]        b_pos1;
  logic signed [33:0] b_net2;
  flux_t              b_avail_c;
  logic               b_go_c;

  always_comb begin
    b_net1 = $signed({a_g[31], a_g}) - $signed({a_mr[31], a_mr});
    b_pos1 = b_net1[32] ? 33'd0 : b_net1;
    b_net2 = $signed({1'b0, b_pos1}) + $signed({{2{a_pool[31]}}, a_pool});
    priority if (b_net2[33])           b_avail_c = '0;
    else if (b_net2[32:31] != 2'b00)   b_avail_c = SAT31;
    else                               b_avail_c = b_net2[30:0];
    b_go_c = !a_g[31] && (a_g != 32'd0) && !a_p[31] && (a_p != 32'd0)
             && (b_avail_c != '0);
  end

  logic        b_v;
  flux_t       b_avail;
  logic        b_go;
  logic [36:0] b_rem, b_den;
  logic [32:0] b_k;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_avail <= b_avail_c;
      b_go    <= b_go_c;
      // 8P < 10P + 25G whenever G > 0; 10P + 25G needs 37 bits at full scale
      b_rem   <= {3'b0, a_p[30:0], 3'b0};
      b_den   <= {6'b0, a_p[30:0]} * 37'd10 + {6'b0, a_g[30:0]} * 37'd25;
      b_k     <= {17'b0, stem_per_leaf} * {16'b0, 17'd4096 + {1'b0, coarse_root_per_stem}};
    end
  end

  // ---- root fraction froot = 8P*2^24 / (10P + 25G)
  logic        r_v;
  logic [23:0] r_froot;
  logic [64:0] r_pay;

  alnd_div #(.DW(37), .QW(24), .PW(65)) u_div_froot (
    .clk, .rst, .en,
    .in_valid (b_v),
    .in_rem   (b_rem),
    .in_lo    (24'd0),
    .in_den   (b_den),
    .in_pay   ({b_go, b_avail, b_k}),
    .out_valid(r_v),
    .out_quo  (r_froot),
    .out_pay  (r_pay)
  );

  // ---- stage C: leaf fraction operands
  logic        c_v;
  logic [88:0] c_pay;
  logic [33:0] c_rem, c_den;
  logic [24:0] c_lo;
  logic [24:0] c_rest;

  assign c_rest = ONE_Q24 - {1'b0, r_froot};

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= r_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_pay <= {r_pay, r_froot};
      c_rem <= {10'b0, c_rest[24:1]};
      c_lo  <= {c_rest[0], 24'd0};
      c_den <= {9'b0, ONE_Q24} + {1'b0, r_pay[32:0]};
    end
  end

  // ---- tree leaf fraction (2^24 - froot)*2^24 / (2^24 + K)
  logic        l_v;
  logic [24:0] l_fleaf;
  logic [88:0] l_pay;

  alnd_div #(.DW(34), .QW(25), .PW(89)) u_div_fleaf (
    .clk, .rst, .en,
    .in_valid (c_v),
    .in_rem   (c_rem),
    .in_lo    (c_lo),
    .in_den   (c_den),
    .in_pay   (c_pay),
    .out_valid(l_v),
    .out_quo  (l_fleaf),
    .out_pay  (l_pay)
  );

  // ---- stage D: pick allocation, carbon sum S, wood products
  logic [23:0] l_froot;
  logic [32:0] l_k;
  flux_t       l_avail;
  logic        l_go;
  logic [24:0] d_fleaf_c;
  logic [12:0] d_f4;
  logic [45:0] d_klw_c, d_kdw_c;

  always_comb begin
    l_froot   = l_pay[23:0];
    l_k       = l_pay[56:24];
    l_avail   = l_pay[87:57];
    l_go      = l_pay[88];
    d_fleaf_c = is_tree ? l_fleaf : (ONE_Q24 - {1'b0, l_froot});
    d_f4      = (live_wood_fraction > FRAC_ONE) ? FRAC_ONE : live_wood_fraction;
    d_klw_c   = {13'b0, l_k} * {33'b0, d_f4};
    d_kdw_c   = {13'b0, l_k} * {33'b0, FRAC_ONE - d_f4};
  end

  logic        d_v;
  logic [24:0] d_fleaf;
  logic [23:0] d_froot;
  logic [36:0] d_klw, d_kdw;
  logic [33:0] d_s;
  flux_t       d_avail;
  logic        d_go;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= l_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_fleaf <= d_fleaf_c;
      d_froot <= l_froot;
      // the wood terms vanish for grass
      d_klw   <= is_tree ? d_klw_c[44:8] : 37'd0;
      d_kdw   <= is_tree ? d_kdw_c[44:8] : 37'd0;
      d_s     <= {9'b0, d_fleaf_c} + {10'b0, l_froot} + (is_tree ? {1'b0, l_k} : 34'd0);
      d_avail <= l_avail;
      d_go    <= l_go;
    end
  end

  // ---- four N:C terms in parallel
  logic        n_v0, n_v1, n_v2, n_v3;
  logic [32:0] n_leaf, n_froot, n_lw, n_dw;
  flux_t       n_avail;
  logic [16:0] n_s_lo;
  logic [16:0] n_s_hi;
  logic        n_go;

  alnd_div #(.DW(16), .QW(33), .PW(31)) u_div_leaf (
    .clk, .rst, .en,
    .in_valid (d_v),
    .in_rem   (16'd0),
    .in_lo    ({4'b0, d_fleaf, 4'b0}),
    .in_den   (cn_floor(leaf_cn)),
    .in_pay   (d_avail),
    .out_valid(n_v0),
    .out_quo  (n_leaf),
    .out_pay  (n_avail)
  );

  alnd_div #(.DW(16), .QW(33), .PW(17)) u_div_froot_n (
    .clk, .rst, .en,
    .in_valid (d_v),
    .in_rem   (16'd0),
    .in_lo    ({5'b0, d_froot, 4'b0}),
    .in_den   (cn_floor(fine_root_cn)),
    .in_pay   (d_s[16:0]),
    .out_valid(n_v1),
    .out_quo  (n_froot),
    .out_pay  (n_s_lo)
  );

  alnd_div #(.DW(16), .QW(33), .PW(1)) u_div_live (
    .clk, .rst, .en,
    .in_valid (d_v),
    .in_rem   ({12'b0, d_klw[36:33]}),
    .in_lo    (d_klw[32:0]),
    .in_den   (cn_floor(live_wood_cn)),
    .in_pay   (d_go),
    .out_valid(n_v2),
    .out_quo  (n_lw),
    .out_pay  (n_go)
  );

  alnd_div #(.DW(16), .QW(33), .PW(17)) u_div_dead (
    .clk, .rst, .en,
    .in_valid (d_v),
    .in_rem   ({12'b0, d_kdw[36:33]}),
    .in_lo    (d_kdw[32:0]),
    .in_den   (cn_floor(dead_wood_cn)),
    .in_pay   (d_s[33:17]),
    .out_valid(n_v3),
    .out_quo  (n_dw),
    .out_pay  (n_s_hi)
  );

  // ---- stage E: nitrogen allometry N
  logic        e_v;
  logic [34:0] e_n;
  logic [33:0] e_s;
  flux_t       e_avail;
  logic        e_go;

  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (en) e_v <= n_v0 & n_v1 & n_v2 & n_v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_n     <= {2'b0, n_leaf} + {2'b0, n_froot} + {2'b0, n_lw} + {2'b0, n_dw};
      e_s     <= {n_s_hi, n_s_lo};
      e_avail <= n_avail;
      e_go    <= n_go;
    end
  end

  // ---- stage F: partial products of avail*N, divisor (4096 + growth resp) * S
  logic        f_v;
  logic [48:0] f_pl;
  logic [47:0] f_ph;
  logic [47:0] f_den;
  logic        f_go;

  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= e_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_pl  <= {18'b0, e_avail} * {31'b0, e_n[17:0]};
      f_ph  <= {17'b0, e_avail} * {31'b0, e_n[34:18]};
      f_den <= {14'b0, e_s} * {34'b0, RESP_SCALE};
      f_go  <= e_go;
    end
  end

  // carry available carbon alongside the demand path
  flux_t f_avail, g_avail, h_avail;
  always_ff @(posedge clk) begin
    if (en) begin
      f_avail <= e_avail;
      g_avail <= f_avail;
      h_avail <= g_avail;
    end
  end

  // ---- stage G: full product, dividend = product * 4096
  logic        g_v;
  logic [65:0] g_prod;
  logic [47:0] g_den;
  logic        g_go;

  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else if (en) g_v <= f_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_prod <= {f_ph, 18'b0} + {17'b0, f_pl};
      g_den  <= f_den;
      g_go   <= f_go;
    end
  end

  // ---- stage H: saturation test on the upper dividend bits
  logic        h_v;
  logic [47:0] h_rem;
  logic [30:0] h_lo;
  logic [47:0] h_den;
  logic        h_sat, h_zero;

  always_ff @(posedge clk) begin
    if (rst) h_v <= 1'b0;
    else if (en) h_v <= g_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h_rem  <= {1'b0, g_prod[65:19]};
      h_lo   <= {g_prod[18:0], 12'd0};
      h_den  <= g_den;
      h_sat  <= ({1'b0, g_prod[65:19]} >= g_den);
      h_zero <= !g_go || (g_den == 48'd0);
    end
  end

  // ---- demand division
  logic        q_v;
  flux_t       q_quo;
  logic [32:0] q_pay;
  flux_t       q_demand;

  alnd_div #(.DW(48), .QW(31), .PW(33)) u_div_demand (
    .clk, .rst, .en,
    .in_valid (h_v),
    .in_rem   (h_sat ? 48'd0 : h_rem),
    .in_lo    (h_lo),
    .in_den   (h_den),
    .in_pay   ({h_zero, h_sat, h_avail}),
    .out_valid(q_v),
    .out_quo  (q_quo),
    .out_pay  (q_pay)
  );

  always_comb begin
    priority if (q_pay[32]) q_demand = '0;
    else if (q_pay[31])     q_demand = SAT31;
    else                    q_demand = q_quo;
  end

  // ---- output register and skid register
  logic        out_v;
  logic [61:0] out_word, sk_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (m_tready || !out_v) begin
      // drain the skid first, else take the pipeline head
      out_v <= sk_v || q_v;
      sk_v  <= 1'b0;
    end else if (en && q_v) begin
      sk_v  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_v) begin
      out_word <= sk_v ? sk_word : {q_demand, q_pay[30:0]};
    end else if (en && q_v) begin
      sk_word <= {q_demand, q_pay[30:0]};
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {2'b00, out_word};

endmodule
`default_nettype wire

// ----- tb/tb_allometric_nitrogen_demand.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Nitrogen demand testbench: a table of directed words and then random words are pushed
// through the stream port under several register settings. Each word's result is predicted
// or typed in the table; every result word is compared field by field with the oldest one.
module tb_allometric_nitrogen_demand
  import alnd_pkg::*;
;

  localparam int GROWTH_Q12 = 1229;
  localparam int LATENCY = 122;
  localparam logic [63:0] SAT = 64'h7FFF_FFFF;

  typedef struct packed {
    flux_t avail;
    flux_t demand;
  } demand_t;

  typedef struct packed {
    logic [31:0] gross;
    logic [31:0] pot;
    logic [31:0] resp;
    logic [31:0] pool;
    logic        typed;
    demand_t     want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = REG_IS_TREE;
  logic [15:0]  cfg_data = '0;

  allometric_nitrogen_demand #(.GROWTH_RESP_Q12(GROWTH_Q12)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the register file, at the block's widths
  logic        sh_tree;
  logic [15:0] sh_coarse, sh_stem;
  logic [12:0] sh_live_fr;
  logic [15:0] sh_leaf_cn, sh_froot_cn, sh_live_cn, sh_dead_cn;

  demand_t pending_demand[$];
  int      errors = 0;
  int      words_sent = 0;
  int      words_seen = 0;
  bit      quiet = 1'b0;
  int      stall_left = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, words_seen);
    errors++;
  endtask

  // expected avail carbon and demand for one word under the shadow registers
  function automatic demand_t predict_demand(logic [31:0] g_in, logic [31:0] p_in,
                                             logic [31:0] r_in, logic [31:0] l_in);
    longint gs, ps, net;
    logic [63:0] av, g, p, froot, k, f4, cnl, cnfr, cnlw, cndw, fleaf, s, n, dv;
    logic [127:0] q;
    demand_t r;
    gs = longint'($signed(g_in));
    ps = longint'($signed(p_in));
    net = gs - longint'($signed(r_in));
    if (net < 0) net = 0;
    net = net + longint'($signed(l_in));
    if (net < 0) net = 0;
    av = net;
    if (av > SAT) av = SAT;
    r.avail = av[30:0];
    r.demand = '0;
    if (gs > 0 && ps > 0 && av != 0) begin
      g = gs;
      p = ps;
      froot = ((64'd8 * p) << 24) / (64'd10 * p + 64'd25 * g);
      // C:N below 1.0 counts as 1.0
      cnl  = (sh_leaf_cn  < 16) ? 64'd16 : 64'(sh_leaf_cn);
      cnfr = (sh_froot_cn < 16) ? 64'd16 : 64'(sh_froot_cn);
      if (sh_tree) begin
        k = 64'(sh_stem) * (64'd4096 + 64'(sh_coarse));
        f4 = (sh_live_fr > 4096) ? 64'd4096 : 64'(sh_live_fr);
        cnlw = (sh_live_cn < 16) ? 64'd16 : 64'(sh_live_cn);
        cndw = (sh_dead_cn < 16) ? 64'd16 : 64'(sh_dead_cn);
        fleaf = ((64'd16777216 - froot) << 24) / (64'd16777216 + k);
        s = fleaf + froot + k;
        n = fleaf * 16 / cnl + froot * 16 / cnfr + (k * f4 * 16) / (cnlw * 4096)
            + (k * (64'd4096 - f4) * 16) / (cndw * 4096);
      end else begin
        fleaf = 64'd16777216 - froot;
        s = fleaf + froot;
        n = fleaf * 16 / cnl + froot * 16 / cnfr;
      end
      dv = 64'(4096 + GROWTH_Q12) * s;
      if (dv != 0) begin
        q = (128'(av * 4096) * 128'(n)) / 128'(dv);
        r.demand = (q > 128'(SAT)) ? SAT[30:0] : q[30:0];
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_IS_TREE:      sh_tree = val[0];
      REG_COARSE_ROOT:  sh_coarse = val;
      REG_STEM_LEAF:    sh_stem = val;
      REG_LIVE_WOOD_FR: sh_live_fr = val[12:0];
      REG_LEAF_CN:      sh_leaf_cn = val;
      REG_FROOT_CN:     sh_froot_cn = val;
      REG_LIVE_CN:      sh_live_cn = val;
      REG_DEAD_CN:      sh_dead_cn = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic t, logic [15:0] f2, logic [15:0] f3, logic [15:0] f4,
                           logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                           logic [15:0] c3);
    write_reg(REG_IS_TREE, {15'd0, t});
    write_reg(REG_COARSE_ROOT, f2);
    write_reg(REG_STEM_LEAF, f3);
    write_reg(REG_LIVE_WOOD_FR, f4);
    write_reg(REG_LEAF_CN, c0);
    write_reg(REG_FROOT_CN, c1);
    write_reg(REG_LIVE_CN, c2);
    write_reg(REG_DEAD_CN, c3);
  endtask

  function automatic logic [15:0] pick_cn();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 16));
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(100, 9000));
    endcase
  endfunction

  task automatic write_random_regs();
    write_all(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom_range(0, 20000)),
              16'($urandom_range(0, 8191)), pick_cn(), pick_cn(), pick_cn(), pick_cn());
  endtask

  task automatic wait_drained();
    while (pending_demand.size() != 0) @(posedge clk);
  endtask

  // hold the word on the bus until it is taken, then queue its prediction
  task automatic send_word(row_t w);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {w.pool, w.resp, w.pot, w.gross};
    do @(posedge clk); while (!s_tready);
    pending_demand.push_back(w.typed ? w.want : predict_demand(w.gross, w.pot, w.resp, w.pool));
    words_sent++;
  endtask

  task automatic lower_valid();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_flux(int unsigned span, bit allow_neg);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = $urandom_range(0, 3);
      default: v = $urandom_range(0, span);
    endcase
    if (allow_neg && $urandom_range(0, 3) == 0) v = -v;
    return v;
  endfunction

  task automatic send_random(int count);
    row_t w;
    repeat (count) begin
      w = '0;
      w.gross = pick_flux(32'h0014_0000, $urandom_range(0, 7) == 0);
      w.pot   = pick_flux(32'h0018_0000, $urandom_range(0, 7) == 0);
      w.resp  = pick_flux(32'h0008_0000, 1'b1);
      w.pool  = pick_flux(32'h0004_0000, 1'b1);
      send_word(w);
    end
  endtask

  // directed words: zero, extremes and each special case
  row_t directed[10];
  initial begin
    directed[0] = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{31'd0, 31'd0}};
    directed[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0};
    // non-positive gross: demand zero, pool passes through
    directed[2] = '{32'hFFFF_FFFF, 32'd100000, 32'd0, 32'h0001_0000, 1'b1,
                    '{31'h0001_0000, 31'd0}};
    // non-positive potential
    directed[3] = '{32'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b1, '{31'h0001_0000, 31'd0}};
    // no available carbon
    directed[4] = '{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFB, 1'b1,
                    '{31'd0, 31'd0}};
    directed[5] = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                    '{31'd0, 31'd0}};
    directed[6] = '{32'h0005_0000, 32'h0006_0000, 32'h0001_0000, 32'hFFFE_0000, 1'b0, '0};
    directed[7] = '{32'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0};
    directed[8] = '{32'h0003_4000, 32'h0004_0000, 32'h0000_8000, 32'h0000_1000, 1'b0, '0};
    directed[9] = '{32'd0, 32'h0001_0000, 32'd0, 32'h7FFF_FFFF, 1'b1, '{31'h7FFF_FFFF, 31'd0}};
  end

  task automatic send_directed();
    foreach (directed[i]) send_word(directed[i]);
  endtask

  // result side: random stall bursts, none while quiet
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rst && !quiet && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    demand_t want;
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      if (pending_demand.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 64'd0);
      end else begin
        want = pending_demand.pop_front();
        if (m_tdata[30:0] !== want.avail)
          report_mismatch("avail_carbon", 64'(m_tdata[30:0]), 64'(want.avail));
        if (m_tdata[61:31] !== want.demand)
          report_mismatch("nitrogen_demand", 64'(m_tdata[61:31]), 64'(want.demand));
        if (m_tdata[63:62] !== 2'b00)
          report_mismatch("pad bits", 64'(m_tdata[63:62]), 64'd0);
      end
    end
  end

  initial begin
    sh_tree = 1'b1;
    sh_coarse = 16'd901;
    sh_stem = 16'd9011;
    sh_live_fr = 13'd410;
    sh_leaf_cn = 16'd672;
    sh_froot_cn = 16'd672;
    sh_live_cn = 16'd800;
    sh_dead_cn = 16'd7968;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values
    send_directed();
    send_random(190);
    lower_valid();
    wait_drained();

    // largest allometry and C:N
    write_all(1'b1, 16'hFFFF, 16'hFFFF, 16'd4096, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_directed();
    send_random(190);
    lower_valid();
    wait_drained();

    // smallest legal values
    write_all(1'b1, 16'd0, 16'd0, 16'd0, 16'd16, 16'd16, 16'd16, 16'd16);
    send_directed();
    send_random(190);
    lower_valid();
    wait_drained();

    // C:N below 1.0 and live wood fraction above one
    write_all(1'b1, 16'($urandom), 16'($urandom_range(1, 20000)),
              16'($urandom_range(4097, 8191)), 16'($urandom_range(0, 15)),
              16'($urandom_range(0, 15)), 16'd0, 16'($urandom_range(0, 15)));
    send_random(200);
    lower_valid();
    wait_drained();

    // grass
    write_all(1'b0, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 4096)),
              pick_cn(), pick_cn(), pick_cn(), pick_cn());
    send_directed();
    send_random(190);
    lower_valid();
    wait_drained();

    // random settings; hold the sender once until the pipe has emptied
    write_random_regs();
    send_random(100);
    lower_valid();
    wait_drained();
    send_random(100);
    lower_valid();
    wait_drained();

    // last stretch with no idling on either side
    write_random_regs();
    quiet = 1'b1;
    send_random(200);
    lower_valid();
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);

    $display("covered %0d words over tree, grass, extreme and clamped register settings",
             words_sent);
    $display("result words checked: %0d, leftover predictions: %0d", words_seen,
             pending_demand.size());
    if (errors == 0 && pending_demand.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/alnd_pkg.sv
hdl/alnd_div.sv
hdl/allometric_nitrogen_demand.sv
tb/tb_allometric_nitrogen_demand.sv
